### hw/rtl/pkhu_pkg.sv
// ----------------------------------------------------------------------------
// pkhu_pkg
// Types, key addresses and move tables shared by the position key hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package pkhu_pkg;

    localparam int KEY_WORDS_DEF = 1024;

    localparam logic [9:0] SIDE_KEY    = 10'd768;
    localparam logic [9:0] CASTLE_KEY0 = 10'd769;
    localparam logic [9:0] EP_KEY0     = 10'd773;
    localparam logic [9:0] EP_KEY1     = 10'd781;

    localparam logic [6:0] NO_SQUARE = 7'd64;

    localparam logic [2:0] PC_PAWN  = 3'd0;
    localparam logic [2:0] PC_ROOK  = 3'd3;
    localparam logic [2:0] PC_KING  = 3'd5;
    localparam logic [2:0] PC_COUNT = 3'd6;

    localparam logic [3:0] MT_NORMAL  = 4'd0;
    localparam logic [3:0] MT_CASTLE0 = 4'd1;
    localparam logic [3:0] MT_CASTLE3 = 4'd4;
    localparam logic [3:0] MT_PROMO0  = 4'd5;
    localparam logic [3:0] MT_PROMO3  = 4'd8;

    typedef enum logic [2:0] {
        KIND_LOAD   = 3'd0,
        KIND_START  = 3'd1,
        KIND_ADD    = 3'd2,
        KIND_FINISH = 3'd3,
        KIND_MOVE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        STEP_FROM    = 4'd0,
        STEP_TO      = 4'd1,
        STEP_CAPTURE = 4'd2,
        STEP_EXTRA   = 4'd3,
        STEP_CASTLE0 = 4'd4,
        STEP_CASTLE1 = 4'd5,
        STEP_CASTLE2 = 4'd6,
        STEP_CASTLE3 = 4'd7,
        STEP_EP_OLD  = 4'd8,
        STEP_EP_NEW  = 4'd9,
        STEP_SIDE    = 4'd10
    } t_step;

    typedef struct packed {
        logic [63:0] word;
        logic [9:0]  key_index;
        logic [5:0]  from_square;
        logic [5:0]  to_square;
        logic [3:0]  move_code;
        logic [2:0]  piece;
        logic        black;
        logic [2:0]  captured_piece;
        logic [3:0]  castle_rights;
        logic [6:0]  en_passant_square;
        logic        black_to_play;
    } t_item;

    function automatic logic [9:0] piece_addr(logic [5:0] sq, logic [2:0] pc, logic col);
        return ({4'b0, sq} << 3) + ({4'b0, sq} << 2) + {6'b0, pc, 1'b0} + {9'b0, col};
    endfunction

    function automatic logic ep_has_key(logic [6:0] sq);
        return (sq[6:3] == 4'd2) || (sq[6:3] == 4'd5);
    endfunction

    function automatic logic [9:0] ep_addr(logic [6:0] sq);
        return ((sq[6:3] == 4'd2) ? EP_KEY0 : EP_KEY1) + {7'b0, sq[2:0]};
    endfunction

    function automatic logic [5:0] king_dst(logic [1:0] k);
        logic [5:0] sq;
        unique case (k)
            2'd0: sq = 6'd6;
            2'd1: sq = 6'd62;
            2'd2: sq = 6'd2;
            2'd3: sq = 6'd58;
        endcase
        return sq;
    endfunction

    function automatic logic [5:0] rook_src(logic [1:0] k);
        logic [5:0] sq;
        unique case (k)
            2'd0: sq = 6'd7;
            2'd1: sq = 6'd63;
            2'd2: sq = 6'd0;
            2'd3: sq = 6'd56;
        endcase
        return sq;
    endfunction

    function automatic logic [5:0] rook_dst(logic [1:0] k);
        logic [5:0] sq;
        unique case (k)
            2'd0: sq = 6'd5;
            2'd1: sq = 6'd61;
            2'd2: sq = 6'd3;
            2'd3: sq = 6'd59;
        endcase
        return sq;
    endfunction

    function automatic logic [2:0] promo_piece(logic [1:0] k);
        logic [2:0] pc;
        unique case (k)
            2'd0: pc = 3'd4;
            2'd1: pc = 3'd2;
            2'd2: pc = 3'd3;
            2'd3: pc = 3'd1;
        endcase
        return pc;
    endfunction

    // right is lost when its rook square is touched or its king leaves home
    function automatic logic castle_hit(logic [1:0] k, logic [5:0] org, logic [5:0] dst);
        logic hit;
        unique case (k)
            2'd0: hit = (org == 6'd7)  || (dst == 6'd7)  || (org == 6'd4);
            2'd1: hit = (org == 6'd63) || (dst == 6'd63) || (org == 6'd60);
            2'd2: hit = (org == 6'd0)  || (dst == 6'd0)  || (org == 6'd4);
            2'd3: hit = (org == 6'd56) || (dst == 6'd56) || (org == 6'd60);
        endcase
        return hit;
    endfunction

    function automatic t_step first_step(logic [2:0] kind);
        t_step s;
        priority if (kind == KIND_START)  s = STEP_CASTLE0;
        else if (kind == KIND_FINISH)     s = STEP_SIDE;
        else                              s = STEP_FROM;
        return s;
    endfunction

    function automatic t_step last_step(logic [2:0] kind);
        t_step s;
        priority if (kind == KIND_START)  s = STEP_EP_OLD;
        else if (kind == KIND_ADD)        s = STEP_FROM;
        else                              s = STEP_SIDE;
        return s;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pkhu_key_ram.sv
// ----------------------------------------------------------------------------
// pkhu_key_ram
// Key memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pkhu_key_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [63:0]   i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [63:0]   o_rd_data
);

    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/position_key_hash_update.sv
// ----------------------------------------------------------------------------
// position_key_hash_update
// Incremental position hash: key load, full build and incremental move.
// ----------------------------------------------------------------------------
// All keys live in one memory with a single read port; a small sequencer walks
// the key list of an item, reading at most one key per cycle and XORing it
// into an accumulator. A key load writes its word into the memory without
// starting the sequencer. Finish and move results wait in an output register,
// so the next item is taken while a result is still pending. Keys must be
// loaded before use; the memory is not cleared after reset.
`default_nettype none

module position_key_hash_update
    import pkhu_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // word, key_index, from_square, to_square, move_code, piece, black,
    // captured_piece, castle_rights, en_passant_square, black_to_play, pad
    input  wire logic [111:0] s_axis_tdata,
    // kind
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hash_value, next_ep_square, pad
    output logic      [71:0]  m_axis_tdata
);

    localparam int AW = $clog2(KEY_WORDS);

    t_state      r_state, n_state;
    t_step       r_step;
    logic [2:0]  r_kind;
    t_item       r_item;
    logic [63:0] r_acc;
    logic [63:0] r_run_hash;
    logic        r_xv;
    logic        r_out_valid;
    logic [63:0] r_out_hash;
    logic [6:0]  r_out_ep;

    t_item       in_item;
    logic        in_xfer;
    logic        wr_en;
    logic        rd_en;
    logic [9:0]  rd_addr;
    logic        step_en;
    logic [63:0] rd_data;
    logic        has_result;
    logic        out_free;

    logic        is_normal, is_castle, is_promo;
    logic [1:0]  ck, pk;
    logic        oc;
    logic        ep_valid, ep_capture;
    logic [6:0]  nep;
    logic [3:0]  ro, rd;

    assign in_item = '{
        word:              s_axis_tdata[63:0],
        key_index:         s_axis_tdata[73:64],
        from_square:       s_axis_tdata[79:74],
        to_square:         s_axis_tdata[85:80],
        move_code:         s_axis_tdata[89:86],
        piece:             s_axis_tdata[92:90],
        black:             s_axis_tdata[93],
        captured_piece:    s_axis_tdata[96:94],
        castle_rights:     s_axis_tdata[100:97],
        en_passant_square: s_axis_tdata[107:101],
        black_to_play:     s_axis_tdata[108]
    };

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign wr_en   = in_xfer && (s_axis_tuser == KIND_LOAD)
                     && ({1'b0, in_item.key_index} < 11'(KEY_WORDS));

    // ---- move decode ----
    always_comb begin
        logic [3:0] ck4, pk4;
        is_normal  = (r_item.move_code == MT_NORMAL);
        is_castle  = (r_item.move_code >= MT_CASTLE0) && (r_item.move_code <= MT_CASTLE3);
        is_promo   = (r_item.move_code >= MT_PROMO0) && (r_item.move_code <= MT_PROMO3);
        ck4        = r_item.move_code - MT_CASTLE0;
        pk4        = r_item.move_code - MT_PROMO0;
        ck         = ck4[1:0];
        pk         = pk4[1:0];
        oc         = ~r_item.black;
        ro         = {1'b0, r_item.from_square[5:3]};
        rd         = {1'b0, r_item.to_square[5:3]};
        ep_valid   = ~r_item.en_passant_square[6];
        ep_capture = is_normal && (r_item.piece == PC_PAWN) && ep_valid
                     && (r_item.to_square == r_item.en_passant_square[5:0]);
        nep        = NO_SQUARE;
        if (is_normal && (r_item.piece == PC_PAWN) && !ep_capture) begin
            if (rd == ro + 4'd2) begin
                nep = {1'b0, r_item.from_square + 6'd8};
            end else if ((ro >= 4'd2) && (rd == ro - 4'd2)) begin
                nep = {1'b0, r_item.from_square - 6'd8};
            end
        end
    end

    // ---- key address and enable of the current step ----
    always_comb begin
        logic mv;
        mv      = (r_kind == KIND_MOVE);
        rd_addr = SIDE_KEY;
        step_en = 1'b0;
        unique case (r_step)
            STEP_FROM: begin
                rd_addr = is_castle && mv
                        ? piece_addr(r_item.from_square, PC_KING, ck[0])
                        : piece_addr(r_item.from_square, r_item.piece, r_item.black);
                step_en = mv ? (is_normal || is_castle || is_promo)
                             : (r_item.piece < PC_COUNT);
            end
            STEP_TO: begin
                priority if (is_castle)
                    rd_addr = piece_addr(king_dst(ck), PC_KING, ck[0]);
                else if (is_promo)
                    rd_addr = piece_addr(r_item.to_square, promo_piece(pk), r_item.black);
                else
                    rd_addr = piece_addr(r_item.to_square, r_item.piece, r_item.black);
                step_en = is_normal || is_castle || is_promo;
            end
            STEP_CAPTURE: begin
                if (is_castle) begin
                    rd_addr = piece_addr(rook_src(ck), PC_ROOK, ck[0]);
                    step_en = 1'b1;
                end else begin
                    rd_addr = piece_addr(r_item.to_square, r_item.captured_piece, oc);
                    step_en = (is_normal || is_promo) && (r_item.captured_piece < PC_COUNT);
                end
            end
            STEP_EXTRA: begin
                if (is_castle) begin
                    rd_addr = piece_addr(rook_dst(ck), PC_ROOK, ck[0]);
                    step_en = 1'b1;
                end else begin
                    rd_addr = piece_addr({r_item.from_square[5:3], r_item.to_square[2:0]},
                                         PC_PAWN, oc);
                    step_en = ep_capture;
                end
            end
            STEP_CASTLE0, STEP_CASTLE1, STEP_CASTLE2, STEP_CASTLE3: begin
                rd_addr = CASTLE_KEY0 + {8'b0, r_step[1:0]};
                step_en = r_item.castle_rights[r_step[1:0]]
                          && (!mv || castle_hit(r_step[1:0], r_item.from_square,
                                                r_item.to_square));
            end
            STEP_EP_OLD: begin
                rd_addr = ep_addr(r_item.en_passant_square);
                step_en = ep_has_key(r_item.en_passant_square);
            end
            STEP_EP_NEW: begin
                rd_addr = ep_addr(nep);
                step_en = ep_has_key(nep);
            end
            STEP_SIDE: begin
                rd_addr = SIDE_KEY;
                step_en = mv || r_item.black_to_play;
            end
            default: begin
                rd_addr = SIDE_KEY;
                step_en = 1'b0;
            end
        endcase
    end

    // ---- sequencer ----
    assign has_result = (r_kind == KIND_FINISH) || (r_kind == KIND_MOVE);
    assign out_free   = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser >= KIND_START)
                    && (s_axis_tuser <= KIND_MOVE)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                rd_en = step_en;
                if (r_step == last_step(r_kind)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!has_result || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_FROM;
            r_kind      <= KIND_LOAD;
            r_xv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_hash  <= '0;
        end else begin
            r_xv <= rd_en;
            if (r_state == ST_DONE && n_state == ST_IDLE && has_result) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                r_kind <= s_axis_tuser;
                r_step <= first_step(s_axis_tuser);
            end else if (r_state == ST_RUN) begin
                r_step <= t_step'(r_step + 4'd1);
            end
            if (r_state == ST_DONE && n_state == ST_IDLE && r_kind != KIND_MOVE) begin
                r_run_hash <= r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= in_item;
            priority if (s_axis_tuser == KIND_MOVE)  r_acc <= in_item.word;
            else if (s_axis_tuser == KIND_START)     r_acc <= '0;
            else                                     r_acc <= r_run_hash;
        end else if (r_xv) begin
            r_acc <= r_acc ^ rd_data;
        end
        if (r_state == ST_DONE && has_result && out_free) begin
            r_out_hash <= r_acc;
            r_out_ep   <= (r_kind == KIND_MOVE) ? nep : NO_SQUARE;
        end
    end

    pkhu_key_ram #(
        .DEPTH (KEY_WORDS),
        .AW    (AW)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (in_item.key_index[AW-1:0]),
        .i_wr_data (in_item.word),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ep, r_out_hash};

    // ---- assertions ----
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> ({1'b0, rd_addr} < 11'(KEY_WORDS)))
        else $error("key read beyond key memory");

    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (s_axis_tuser == KIND_MOVE || s_axis_tuser == KIND_START
                     || s_axis_tuser == KIND_ADD || s_axis_tuser == KIND_FINISH))
        |=> (r_state == ST_RUN))
        else $error("hash item did not start the sequencer");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && has_result && r_out_valid && !m_axis_tready)
        |=> (r_state == ST_DONE))
        else $error("result dropped while output register busy");

    a_drain_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (!rd_en && $past(r_state) == ST_RUN))
        else $error("drain without a finished key walk");

endmodule

`default_nettype wire

### dv/tb_position_key_hash_update.sv
// ----------------------------------------------------------------------------
// tb_position_key_hash_update
// Self-checking bench for the position key hash block. Each key an item reads is
// loaded first; then directed items, then random full-hash builds, pawn pushes,
// en-passant captures, castles, promotions and noise. A scoreboard predicts
// each hash from its own copy of the key memory and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_position_key_hash_update;
    import pkhu_pkg::*;

    localparam logic [2:0] PC_KNIGHT = 3'd1;
    localparam logic [2:0] PC_BISHOP = 3'd2;
    localparam logic [2:0] PC_QUEEN  = 3'd4;
    localparam logic [2:0] PC_EMPTY  = 3'd6;
    localparam logic [3:0] MT_LAST   = 4'd15;
    localparam int RANDOM_ITEMS = 480;
    // highest key address any item can select is 788
    localparam int KEYS_USED = 789;

    typedef struct packed {
        logic [63:0] hash;
        logic [6:0]  ep;
    } t_hash_result;

    class hash_scoreboard;
        logic [63:0]  keys [1024];
        logic [63:0]  running_hash;
        t_hash_result expected_hashes [$];
        int           mismatches;

        function new();
            running_hash = '0;
            mismatches   = 0;
        endfunction

        function int pending();
            return expected_hashes.size();
        endfunction

        function logic [63:0] piece_key(logic [5:0] sq, logic [2:0] pc, logic col);
            return keys[int'(sq) * 12 + int'(pc) * 2 + int'(col)];
        endfunction

        function logic [63:0] ep_key(logic [6:0] sq);
            int s;
            s = int'(sq);
            if (s >= 16 && s <= 23) return keys[int'(EP_KEY0) + s - 16];
            if (s >= 40 && s <= 47) return keys[int'(EP_KEY1) + s - 40];
            return '0;
        endfunction

        function t_hash_result predict_move(t_item it);
            t_hash_result r;
            logic [63:0]  h;
            logic [6:0]   nep;
            logic         opp;
            logic [1:0]   k;
            logic [2:0]   promo;
            int           ro, rd, base, rook_home, king_home;
            h   = it.word;
            nep = NO_SQUARE;
            opp = ~it.black;
            ro  = int'(it.from_square[5:3]);
            rd  = int'(it.to_square[5:3]);
            if (it.move_code == MT_NORMAL) begin
                h ^= piece_key(it.from_square, it.piece, it.black)
                   ^ piece_key(it.to_square, it.piece, it.black);
                if (it.captured_piece < PC_COUNT)
                    h ^= piece_key(it.to_square, it.captured_piece, opp);
                if (it.piece == PC_PAWN) begin
                    if (it.en_passant_square < NO_SQUARE &&
                        {1'b0, it.to_square} == it.en_passant_square)
                        h ^= piece_key({it.from_square[5:3], it.to_square[2:0]}, PC_PAWN, opp);
                    else if (rd == ro + 2)
                        nep = {1'b0, it.from_square} + 7'd8;
                    else if (ro >= 2 && rd == ro - 2)
                        nep = {1'b0, it.from_square} - 7'd8;
                end
            end else if (it.move_code >= MT_CASTLE0 && it.move_code <= MT_CASTLE3) begin
                // k[0]: black, k[1]: queen side
                k    = 2'(it.move_code - MT_CASTLE0);
                base = k[0] ? 56 : 0;
                h ^= piece_key(it.from_square, PC_KING, k[0])
                   ^ piece_key(6'(base + (k[1] ? 2 : 6)), PC_KING, k[0])
                   ^ piece_key(6'(base + (k[1] ? 0 : 7)), PC_ROOK, k[0])
                   ^ piece_key(6'(base + (k[1] ? 3 : 5)), PC_ROOK, k[0]);
            end else if (it.move_code >= MT_PROMO0 && it.move_code <= MT_PROMO3) begin
                k = 2'(it.move_code - MT_PROMO0);
                case (k)
                    2'd0: promo = PC_QUEEN;
                    2'd1: promo = PC_BISHOP;
                    2'd2: promo = PC_ROOK;
                    default: promo = PC_KNIGHT;
                endcase
                h ^= piece_key(it.from_square, it.piece, it.black)
                   ^ piece_key(it.to_square, promo, it.black);
                if (it.captured_piece < PC_COUNT)
                    h ^= piece_key(it.to_square, it.captured_piece, opp);
            end
            for (int i = 0; i < 4; i++) begin
                base      = (i % 2 == 1) ? 56 : 0;
                rook_home = base + ((i >= 2) ? 0 : 7);
                king_home = base + 4;
                if (it.castle_rights[i] && (int'(it.from_square) == rook_home ||
                    int'(it.to_square) == rook_home || int'(it.from_square) == king_home))
                    h ^= keys[int'(CASTLE_KEY0) + i];
            end
            h ^= ep_key(it.en_passant_square) ^ ep_key(nep) ^ keys[SIDE_KEY];
            r.hash = h;
            r.ep   = nep;
            return r;
        endfunction

        function void note_transfer(logic [2:0] kind, t_item it);
            t_hash_result r;
            logic [63:0]  h;
            case (kind)
                KIND_LOAD: keys[it.key_index] = it.word;
                KIND_START: begin
                    h = ep_key(it.en_passant_square);
                    for (int i = 0; i < 4; i++)
                        if (it.castle_rights[i]) h ^= keys[int'(CASTLE_KEY0) + i];
                    running_hash = h;
                end
                KIND_ADD: begin
                    if (it.piece < PC_COUNT)
                        running_hash ^= piece_key(it.from_square, it.piece, it.black);
                end
                KIND_FINISH: begin
                    if (it.black_to_play) running_hash ^= keys[SIDE_KEY];
                    r.hash = running_hash;
                    r.ep   = NO_SQUARE;
                    expected_hashes.push_back(r);
                end
                KIND_MOVE: expected_hashes.push_back(predict_move(it));
                default: ;
            endcase
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(logic [63:0] hash, logic [6:0] ep);
            t_hash_result want;
            if (expected_hashes.size() == 0) begin
                flag("unexpected result", '0, hash);
                return;
            end
            want = expected_hashes.pop_front();
            if (hash !== want.hash) flag("hash_value", want.hash, hash);
            if (ep !== want.ep) flag("next_ep_square", 64'(want.ep), 64'(ep));
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    int tx_idle_pct = 18;
    int rx_idle_pct = 73;
    int rx_hold_len = 0;
    int rx_hold_left = 0;

    hash_scoreboard sb = new();

    position_key_hash_update DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("** position_key_hash_update: FAILED **");
        $finish;
    end

    // result side: check, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[63:0], m_axis_tdata[70:64]);
        if (rx_hold_len > 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic [2:0] kind, input t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b0, it.black_to_play, it.en_passant_square, it.castle_rights,
                          it.captured_piece, it.black, it.piece, it.move_code,
                          it.to_square, it.from_square, it.key_index, it.word};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_transfer(kind, it);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_item random_item();
        t_item it;
        it.word              = {$urandom, $urandom};
        it.key_index         = 10'($urandom_range(1023));
        it.from_square       = 6'($urandom_range(63));
        it.to_square         = 6'($urandom_range(63));
        it.move_code         = 4'($urandom_range(15));
        it.piece             = 3'($urandom_range(7));
        it.black             = 1'($urandom_range(1));
        it.captured_piece    = 3'($urandom_range(7));
        it.castle_rights     = 4'($urandom_range(15));
        it.en_passant_square = 7'($urandom_range(127));
        it.black_to_play     = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic logic [6:0] random_ep();
        case ($urandom_range(3))
            0: return NO_SQUARE;
            1: return 7'(16 + $urandom_range(7));
            2: return 7'(40 + $urandom_range(7));
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    function automatic t_item move_item(input logic [5:0] org, input logic [5:0] dst,
                                        input logic [3:0] mt, input logic [2:0] pc,
                                        input logic blk, input logic [2:0] cap,
                                        input logic [3:0] rights, input logic [6:0] ep);
        t_item it;
        it                   = random_item();
        it.from_square       = org;
        it.to_square         = dst;
        it.move_code         = mt;
        it.piece             = pc;
        it.black             = blk;
        it.captured_piece    = cap;
        it.castle_rights     = rights;
        it.en_passant_square = ep;
        return it;
    endfunction

    task automatic send_random_group(inout int count);
        t_item it, sq_item;
        int    pick, n, f, ff;
        logic  blk;
        pick = $urandom_range(99);
        f    = $urandom_range(7);
        ff   = (f == 0) ? 1 : (f == 7) ? 6 : f + ($urandom_range(1) ? 1 : -1);
        blk  = 1'($urandom_range(1));
        it   = random_item();
        it.black             = blk;
        it.move_code         = MT_NORMAL;
        it.en_passant_square = random_ep();
        if ($urandom_range(15) != 0) it.piece = 3'($urandom_range(PC_KING));
        if ($urandom_range(2) == 0) it.captured_piece = PC_EMPTY;
        if (pick < 20) begin
            n = $urandom_range(1, 8);
            send_item(KIND_START, it);
            for (int i = 0; i < n; i++) begin
                sq_item = random_item();
                if ($urandom_range(15) != 0) sq_item.piece = 3'($urandom_range(PC_KING));
                send_item(KIND_ADD, sq_item);
            end
            send_item(KIND_FINISH, it);
            count += n + 2;
            return;
        end else if (pick < 30) begin
            it.piece          = PC_PAWN;
            it.captured_piece = PC_EMPTY;
            it.from_square    = 6'(blk ? 48 + f : 8 + f);
            it.to_square      = 6'(blk ? 32 + f : 24 + f);
        end else if (pick < 40) begin
            it.piece             = PC_PAWN;
            it.en_passant_square = 7'(blk ? 16 + f : 40 + f);
            it.to_square         = 6'(it.en_passant_square);
            it.from_square       = 6'(blk ? 24 + ff : 32 + ff);
        end else if (pick < 50) begin
            it.move_code      = 4'(MT_CASTLE0 + $urandom_range(3));
            // black castles have an even code
            it.black          = ~it.move_code[0];
            it.from_square    = it.black ? 6'd60 : 6'd4;
            it.piece          = PC_KING;
            it.captured_piece = PC_EMPTY;
        end else if (pick < 60) begin
            it.move_code   = 4'(MT_PROMO0 + $urandom_range(3));
            it.piece       = PC_PAWN;
            it.from_square = 6'(blk ? 8 + ff : 48 + ff);
            it.to_square   = 6'(blk ? f : 56 + f);
        end else if (pick < 72) begin
            case ($urandom_range(5))
                0: it.to_square = 6'd0;
                1: it.from_square = 6'd4;
                2: it.to_square = 6'd7;
                3: it.from_square = 6'd56;
                4: it.from_square = 6'd60;
                default: it.to_square = 6'd63;
            endcase
        end else if (pick < 88) begin
            // plain random move
        end else if (pick < 91) begin
            it.move_code = 4'($urandom_range(MT_LAST, MT_PROMO3 + 1));
        end else if (pick < 95) begin
            send_item(KIND_LOAD, random_item());
            count++;
            return;
        end else if (pick < 97) begin
            // ignored by the block, not counted
            send_item(3'($urandom_range(7, KIND_MOVE + 1)), random_item());
            return;
        end else begin
            send_item(3'($urandom_range(KIND_MOVE)), random_item());
            count++;
            return;
        end
        send_item(KIND_MOVE, it);
        count++;
    endtask

    initial begin
        t_item it;
        int    sent;
        bit    hold_done, pause_done;
        hold_done  = 0;
        pause_done = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int a = 0; a < KEYS_USED; a++) begin
            it = random_item();
            it.key_index = 10'(a);
            send_item(KIND_LOAD, it);
        end

        // full build, including a finish with nothing started
        it = random_item();
        it.black_to_play = 1'b1;
        send_item(KIND_FINISH, it);
        send_item(KIND_START, move_item(6'd0, 6'd0, MT_NORMAL, PC_PAWN, 1'b0, PC_EMPTY,
                                        4'hf, 7'd16));
        send_item(KIND_ADD, move_item(6'd0, 6'd0, MT_NORMAL, PC_PAWN, 1'b0, PC_EMPTY,
                                      4'h0, NO_SQUARE));
        send_item(KIND_ADD, move_item(6'd63, 6'd0, MT_NORMAL, PC_KING, 1'b1, PC_EMPTY,
                                      4'h0, NO_SQUARE));
        send_item(KIND_ADD, move_item(6'd5, 6'd0, MT_NORMAL, 3'd7, 1'b0, PC_EMPTY,
                                      4'h0, NO_SQUARE));
        it.black_to_play = 1'b0;
        send_item(KIND_FINISH, it);
        it.black_to_play = 1'b1;
        send_item(KIND_FINISH, it);

        // quiet, capture on h8, en-passant capture, double pushes
        send_item(KIND_MOVE, move_item(6'd1, 6'd18, MT_NORMAL, PC_KNIGHT, 1'b0, PC_EMPTY,
                                       4'hf, NO_SQUARE));
        send_item(KIND_MOVE, move_item(6'd27, 6'd63, MT_NORMAL, PC_BISHOP, 1'b0, PC_ROOK,
                                       4'hf, 7'd47));
        send_item(KIND_MOVE, move_item(6'd36, 6'd45, MT_NORMAL, PC_PAWN, 1'b0, PC_EMPTY,
                                       4'h0, 7'd45));
        send_item(KIND_MOVE, move_item(6'd12, 6'd28, MT_NORMAL, PC_PAWN, 1'b0, PC_EMPTY,
                                       4'h3, NO_SQUARE));
        send_item(KIND_MOVE, move_item(6'd51, 6'd35, MT_NORMAL, PC_PAWN, 1'b1, PC_EMPTY,
                                       4'hc, 7'd20));
        for (int i = 0; i < 4; i++)
            send_item(KIND_MOVE, move_item(6'((i % 2 == 1) ? 60 : 4), 6'd0,
                                           4'(MT_CASTLE0 + i),
                                           PC_KING, 1'(i % 2), PC_EMPTY, 4'hf, NO_SQUARE));
        for (int i = 0; i < 4; i++)
            send_item(KIND_MOVE, move_item(6'((i % 2 == 1) ? 9 : 54),
                                           6'((i % 2 == 1) ? 0 : 63), 4'(MT_PROMO0 + i),
                                           PC_PAWN, 1'(i % 2),
                                           (i % 2 == 1) ? PC_KNIGHT : PC_ROOK, 4'hf, 7'd127));
        // unknown move type, bad moving piece
        send_item(KIND_MOVE, move_item(6'd4, 6'd12, MT_LAST, PC_KING, 1'b0, PC_EMPTY,
                                       4'hf, 7'd23));
        send_item(KIND_MOVE, move_item(6'd63, 6'd0, MT_NORMAL, 3'd7, 1'b1, 3'd7,
                                       4'hf, NO_SQUARE));
        send_item(3'(KIND_MOVE + 3), random_item());
        it = random_item();
        it.key_index = 10'd1023;
        send_item(KIND_LOAD, it);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 73 : 0;
            rx_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 18 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                if (ph == 1 && sent >= 80 && !pause_done) begin
                    wait_drained();
                    pause_done = 1;
                end
                if (ph == 2 && sent >= 60 && !hold_done) begin
                    rx_hold_len = 400;
                    hold_done   = 1;
                end
                send_random_group(sent);
            end
        end

        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 50000 && sb.pending() != 0; n++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** position_key_hash_update: PASSED **");
        else
            $display("** position_key_hash_update: FAILED **");
        $finish;
    end

endmodule
